// ===== sv/assert_macros.svh =====
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/afhd_pkg.sv =====
// Types and constants of the audio frame header deframer.
package afhd_pkg;

  // Frame format versions.
  localparam logic [7:0] VER_RAW   = 8'd1;
  localparam logic [7:0] VER_HDR16 = 8'd2;
  localparam logic [7:0] VER_HDR4  = 8'd3;
  localparam logic [7:0] VER_RESET = VER_RAW;

  // Header layout.
  localparam int HDR2_BYTES     = 16;
  localparam int HDR3_BYTES     = 4;
  localparam int MAGIC_BYTES    = 2;
  localparam int TYPE2_POS      = 3;
  localparam int TIME_FIRST     = 8;
  localparam int LEN2_FIRST     = 12;
  localparam int TYPE3_POS      = 0;
  localparam int LEN3_FIRST     = 2;
  localparam logic [15:0] MAGIC2 = 16'h0002;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Frame status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER  = 3'd2;
  localparam logic [2:0] ST_LEN_MISMATCH = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = 2;
  localparam int CNT_BITS   = 3;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_of_frame;
  } in_req_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_status;
    logic [7:0]  packet_type;
    logic [31:0] timestamp;
    logic [31:0] payload_length;
  } result_t;

  // Up to two results produced by one accepted request, in order.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ===== sv/afhd_intf.sv =====
// Handshake channel interfaces of the deframer: input bytes, results, configuration.
interface afhd_in_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] data_byte;
  logic       end_of_frame;

  modport source (output valid, has_byte, data_byte, end_of_frame, input ready);
  modport sink (input valid, has_byte, data_byte, end_of_frame, output ready);
endinterface

interface afhd_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  frame_status;
  logic [7:0]  packet_type;
  logic [31:0] timestamp;
  logic [31:0] payload_length;

  modport source (output valid, result_kind, payload_byte, frame_status, packet_type,
                  timestamp, payload_length, input ready);
  modport sink (input valid, result_kind, payload_byte, frame_status, packet_type,
                timestamp, payload_length, output ready);
endinterface

interface afhd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] format_version;

  modport source (output valid, format_version, input ready);
  modport sink (input valid, format_version, output ready);
endinterface

// ===== sv/afhd_parser.sv =====
// Frame state, header capture and result generation for one accepted request per cycle.
`include "assert_macros.svh"

module afhd_parser import afhd_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_accept_i,
  input  in_req_t    req_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_version_i,
  output push_t      push_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [7:0]            version_q, version_d;
  logic [COUNT_BITS-1:0] byte_count_q, byte_count_d;
  logic [15:0]           magic_q, magic_d;
  logic [7:0]            type_q, type_d;
  logic [31:0]           time_q, time_d;
  logic [31:0]           decl_len_q, decl_len_d;

  logic [COUNT_BITS-1:0] pos;
  logic [COUNT_BITS-1:0] count_nx;
  logic [15:0]           magic_nx;
  logic [7:0]            type_nx;
  logic [31:0]           time_nx;
  logic [31:0]           decl_nx;
  logic                  is_payload;
  logic [63:0]           cnt_ext;
  logic                  sat;
  result_t               pay_res;
  result_t               stat_res;

  // Place the byte by the version in force now.
  always_comb begin
    pos        = byte_count_q;
    count_nx   = byte_count_q;
    magic_nx   = magic_q;
    type_nx    = type_q;
    time_nx    = time_q;
    decl_nx    = decl_len_q;
    is_payload = 1'b0;
    if (req_i.has_byte) begin
      if (pos != CountMax) begin
        count_nx = pos + COUNT_BITS'(1);
      end
      case (version_q)
        VER_RAW: begin
          is_payload = 1'b1;
        end
        VER_HDR16: begin
          if (pos >= COUNT_BITS'(HDR2_BYTES)) begin
            is_payload = 1'b1;
          end else if (pos < COUNT_BITS'(MAGIC_BYTES)) begin
            magic_nx = {magic_q[7:0], req_i.data_byte};
          end else if (pos == COUNT_BITS'(TYPE2_POS)) begin
            type_nx = req_i.data_byte;
          end else if (pos >= COUNT_BITS'(TIME_FIRST) && pos < COUNT_BITS'(LEN2_FIRST)) begin
            time_nx = {time_q[23:0], req_i.data_byte};
          end else if (pos >= COUNT_BITS'(LEN2_FIRST)) begin
            decl_nx = {decl_len_q[23:0], req_i.data_byte};
          end
        end
        VER_HDR4: begin
          if (pos >= COUNT_BITS'(HDR3_BYTES)) begin
            is_payload = 1'b1;
          end else if (pos == COUNT_BITS'(TYPE3_POS)) begin
            type_nx = req_i.data_byte;
          end else if (pos >= COUNT_BITS'(LEN3_FIRST)) begin
            decl_nx = {16'h0000, decl_len_q[7:0], req_i.data_byte};
          end
        end
        default: begin
          is_payload = 1'b0;
        end
      endcase
    end
  end

  // Status of the frame as it stands after this request's byte.
  always_comb begin
    cnt_ext  = 64'(count_nx);
    sat      = (count_nx == CountMax);
    stat_res = '0;
    stat_res.result_kind = KIND_STATUS;
    case (version_q)
      VER_RAW: begin
        if (count_nx == '0) begin
          stat_res.frame_status = ST_TOO_SHORT;
        end else if (sat || (65'(count_nx) > 65'h0_FFFF_FFFF)) begin
          stat_res.frame_status = ST_LEN_MISMATCH;
        end else begin
          stat_res.payload_length = cnt_ext[31:0];
        end
      end
      VER_HDR16: begin
        if (count_nx < COUNT_BITS'(HDR2_BYTES)) begin
          stat_res.frame_status = ST_TOO_SHORT;
        end else if (magic_nx != MAGIC2) begin
          stat_res.frame_status = ST_BAD_HEADER;
        end else if (sat || ({32'h0, decl_nx} != cnt_ext - 64'(HDR2_BYTES))) begin
          stat_res.frame_status = ST_LEN_MISMATCH;
        end else begin
          stat_res.packet_type    = type_nx;
          stat_res.timestamp      = time_nx;
          stat_res.payload_length = decl_nx;
        end
      end
      VER_HDR4: begin
        if (count_nx < COUNT_BITS'(HDR3_BYTES)) begin
          stat_res.frame_status = ST_TOO_SHORT;
        end else if (sat || ({32'h0, decl_nx} != cnt_ext - 64'(HDR3_BYTES))) begin
          stat_res.frame_status = ST_LEN_MISMATCH;
        end else begin
          stat_res.packet_type    = type_nx;
          stat_res.payload_length = decl_nx;
        end
      end
      default: begin
        stat_res.frame_status = ST_UNSUPPORTED;
      end
    endcase
  end

  // Pack the results in order: payload byte first, status last.
  always_comb begin
    pay_res              = '0;
    pay_res.result_kind  = KIND_PAYLOAD;
    pay_res.payload_byte = req_i.data_byte;
    push_o = '0;
    if (req_accept_i) begin
      if (req_i.has_byte && is_payload) begin
        push_o.r0 = pay_res;
        if (req_i.end_of_frame) begin
          push_o.r1 = stat_res;
          push_o.n  = 2'd2;
        end else begin
          push_o.n = 2'd1;
        end
      end else if (req_i.end_of_frame) begin
        push_o.r0 = stat_res;
        push_o.n  = 2'd1;
      end
    end
  end

  always_comb begin
    version_d    = cfg_we_i ? cfg_version_i : version_q;
    byte_count_d = byte_count_q;
    magic_d      = magic_q;
    type_d       = type_q;
    time_d       = time_q;
    decl_len_d   = decl_len_q;
    if (req_accept_i) begin
      if (req_i.end_of_frame) begin
        byte_count_d = '0;
        magic_d      = '0;
        type_d       = '0;
        time_d       = '0;
        decl_len_d   = '0;
      end else begin
        byte_count_d = count_nx;
        magic_d      = magic_nx;
        type_d       = type_nx;
        time_d       = time_nx;
        decl_len_d   = decl_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q    <= VER_RESET;
      byte_count_q <= '0;
      magic_q      <= '0;
      type_q       <= '0;
      time_q       <= '0;
      decl_len_q   <= '0;
    end else begin
      version_q    <= version_d;
      byte_count_q <= byte_count_d;
      magic_q      <= magic_d;
      type_q       <= type_d;
      time_q       <= time_d;
      decl_len_q   <= decl_len_d;
    end
  end

  `ASSERT_IMPL(a_status_last, push_o.n == 2'd2,
               push_o.r0.result_kind == KIND_PAYLOAD && push_o.r1.result_kind == KIND_STATUS,
               "two results must be a payload byte followed by a status")
  `ASSERT_NEXT(a_eof_clears, req_accept_i && req_i.end_of_frame,
               byte_count_q == '0 && decl_len_q == '0,
               "frame state not cleared after end of frame")
  `ASSERT_NEXT(a_idle_holds, !req_accept_i, $stable(byte_count_q),
               "byte count moved without an accepted request")

endmodule

// ===== sv/afhd_result_fifo.sv =====
// Four-entry result queue with two write slots and one read slot per cycle.
`include "assert_macros.svh"

module afhd_result_fifo import afhd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output logic    room_o,
  output logic    valid_o,
  output result_t head_o
);

  result_t             mem_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic [PTR_BITS-1:0] wr_ptr_nx;

  assign valid_o   = (count_q != '0);
  assign head_o    = mem_q[rd_ptr_q];
  // Room for the two results a single request can produce.
  assign room_o    = (count_q <= CNT_BITS'(FIFO_DEPTH - 2));
  assign wr_ptr_nx = wr_ptr_q + PTR_BITS'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_BITS'(push_i.n);
    rd_ptr_d = rd_ptr_q + PTR_BITS'(pop_i);
    count_d  = count_q + CNT_BITS'(push_i.n) - CNT_BITS'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `ASSERT_IMPL(a_push_room, push_i.n != 2'd0, count_q <= CNT_BITS'(FIFO_DEPTH - 2),
               "results pushed without room for two")
  `ASSERT_IMPL(a_pop_valid, pop_i, count_q != '0, "result popped from an empty queue")
  `ASSERT_NEXT(a_fill_track, push_i.n != 2'd0 && !pop_i,
               count_q == $past(count_q) + CNT_BITS'($past(push_i.n)),
               "queue count does not follow the pushed results")

endmodule

// ===== sv/audio_frame_header_deframer.sv =====
// Top level of the audio frame header deframer: parser and result queue.
//
//  Channel   Modport  Moves per request               Notes
//  in_ch_i   sink     has_byte, data_byte, eof mark   one frame byte or empty end marker
//  out_ch_o  source   one result (payload or status)  status always closes a frame
//  cfg_i     sink     format_version                  always ready, write only when idle
//
// One input request is accepted every cycle while the queue has room; its results enter the
// result queue at the next clock edge. A request that forwards a payload byte and also ends
// the frame yields two results, so it occupies two entries in the four-entry result queue.
// The input stalls while fewer than two queue entries are free, so a stalled output
// holds the input off once three results are waiting; requests that yield no result,
// such as header bytes, are accepted without limit until then.
// Reset restores format version 1 and an empty frame at once, with no clearing pass.

module audio_frame_header_deframer import afhd_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  afhd_in_if.sink     in_ch_i,
  afhd_out_if.source  out_ch_o,
  afhd_cfg_if.sink    cfg_i
);

  logic    room;
  logic    req_accept;
  logic    cfg_we;
  logic    pop;
  in_req_t req;
  push_t   push;
  result_t head;

  // Config port never stalls; the user writes only while the block is idle (unenforced).
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  assign in_ch_i.ready    = room;
  assign req_accept       = in_ch_i.valid && in_ch_i.ready;
  assign req.has_byte     = in_ch_i.has_byte;
  assign req.data_byte    = in_ch_i.data_byte;
  assign req.end_of_frame = in_ch_i.end_of_frame;

  // Header capture, byte counting and status evaluation happen in the cycle of
  // acceptance; the results are written straight into the queue registers.
  afhd_parser #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_accept_i (req_accept),
    .req_i        (req),
    .cfg_we_i     (cfg_we),
    .cfg_version_i(cfg_i.format_version),
    .push_o       (push)
  );

  afhd_result_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .room_o (room),
    .valid_o(out_ch_o.valid),
    .head_o (head)
  );

  // The queue head drives the output channel directly.
  assign pop                     = out_ch_o.valid && out_ch_o.ready;
  assign out_ch_o.result_kind    = head.result_kind;
  assign out_ch_o.payload_byte   = head.payload_byte;
  assign out_ch_o.frame_status   = head.frame_status;
  assign out_ch_o.packet_type    = head.packet_type;
  assign out_ch_o.timestamp      = head.timestamp;
  assign out_ch_o.payload_length = head.payload_length;

endmodule
